// ----- src/utf8_stream_validator_assert.svh -----
// assertion macros for the utf-8 stream validator
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define U8SV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8sv assertion failed");
`define U8SV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8sv assertion failed");
`else
`define U8SV_ASSERT_SAME(label, clk, rst, ante, cons)
`define U8SV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/u8sv_pkg.sv -----
// types and constants for the utf-8 stream validator
package u8sv_pkg;

   localparam int ByteWidth  = 8;
   localparam int PointWidth = 21;

   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [PointWidth-1:0] point_type;
   typedef logic [1:0]            count_type;

   localparam byte_type  LEAD2_LO = 8'hC2;
   localparam byte_type  LEAD2_HI = 8'hDF;
   localparam byte_type  LEAD3_LO = 8'hE0;
   localparam byte_type  LEAD3_HI = 8'hEF;
   localparam byte_type  LEAD4_LO = 8'hF0;
   localparam byte_type  LEAD4_HI = 8'hF4;
   localparam byte_type  CONT_MASK = 8'hC0;
   localparam byte_type  CONT_TAG  = 8'h80;

   localparam point_type MIN_THREE  = 21'h000800;
   localparam point_type MIN_FOUR   = 21'h010000;
   localparam point_type SURR_LO    = 21'h00D800;
   localparam point_type SURR_HI    = 21'h00DFFF;
   localparam point_type POINT_MAX  = 21'h10FFFF;

   localparam count_type LEN_ONE   = 2'd1;
   localparam count_type LEN_TWO   = 2'd2;
   localparam count_type LEN_THREE = 2'd3;

endpackage

// ----- src/utf8_stream_validator.sv -----
// utf-8 stream validator: one byte per beat, verdict per byte
// a req beat is captured in the input register, then in the result register, and shows up as a rsp beat
// throughput: one byte per cycle unless rsp_tready is low, which stalls the input and result registers
// the decode of one byte and the state update happen in one pass between them
// reset: synchronous, active high; clears both stage valids and the string state
`include "utf8_stream_validator_assert.svh"

module utf8_stream_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] string_valid, [7:1] zero
   output logic       rsp_tlast    // string_end
);
   import u8sv_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   byte_type  s1_byte_ff;
   logic      s1_last_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_ok_ff, rsp_ok_in;
   logic      rsp_last_ff;

   count_type pending_ff, pending_in;
   count_type seq_len_ff, seq_len_in;
   point_type point_ff, point_in;
   logic      error_seen_ff, error_seen_in;

   logic      advance;
   logic      s1_fire;
   logic      req_fire;
   point_type cont_point;
   count_type pending_dec;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign cont_point  = {point_ff[PointWidth-7:0], s1_byte_ff[5:0]};
   assign pending_dec = pending_ff - LEN_ONE;

   always_comb begin
      pending_in    = pending_ff;
      seq_len_in    = seq_len_ff;
      point_in      = point_ff;
      error_seen_in = error_seen_ff;
      if (!error_seen_ff) begin
         if (pending_ff == '0) begin
            case (s1_byte_ff) inside
               8'h00: begin
                  error_seen_in = 1'b1;
               end
               [8'h01:8'h7F]: begin
               end
               [LEAD2_LO:LEAD2_HI]: begin
                  pending_in = LEN_ONE;
                  seq_len_in = LEN_ONE;
                  point_in   = {16'd0, s1_byte_ff[4:0]};
               end
               [LEAD3_LO:LEAD3_HI]: begin
                  pending_in = LEN_TWO;
                  seq_len_in = LEN_TWO;
                  point_in   = {17'd0, s1_byte_ff[3:0]};
               end
               [LEAD4_LO:LEAD4_HI]: begin
                  pending_in = LEN_THREE;
                  seq_len_in = LEN_THREE;
                  point_in   = {18'd0, s1_byte_ff[2:0]};
               end
               default: begin
                  error_seen_in = 1'b1;
               end
            endcase
         end else if ((s1_byte_ff & CONT_MASK) != CONT_TAG) begin
            error_seen_in = 1'b1;
         end else begin
            point_in   = cont_point;
            pending_in = pending_dec;
            if (pending_dec == '0) begin
               if ((seq_len_ff == LEN_TWO && cont_point < MIN_THREE) ||
                   (seq_len_ff == LEN_THREE && cont_point < MIN_FOUR) ||
                   (cont_point >= SURR_LO && cont_point <= SURR_HI) ||
                   (cont_point > POINT_MAX)) begin
                  error_seen_in = 1'b1;
               end
            end
         end
      end
      if (s1_last_ff && pending_in != '0) begin
         error_seen_in = 1'b1;
      end
      rsp_ok_in = !error_seen_in;
      if (s1_last_ff) begin
         pending_in    = '0;
         seq_len_in    = '0;
         point_in      = '0;
         error_seen_in = 1'b0;
      end
   end

   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pending_ff    <= '0;
         seq_len_ff    <= '0;
         point_ff      <= '0;
         error_seen_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            pending_ff    <= pending_in;
            seq_len_ff    <= seq_len_in;
            point_ff      <= point_in;
            error_seen_ff <= error_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_fire) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff};
   assign rsp_tlast  = rsp_last_ff;

   `U8SV_ASSERT_NEXT(a_end_clears, clock, reset, s1_fire && s1_last_ff,
      pending_ff == '0 && seq_len_ff == '0 && !error_seen_ff)
   `U8SV_ASSERT_SAME(a_pending_in_seq, clock, reset, pending_ff != '0,
      seq_len_ff != '0 && pending_ff <= seq_len_ff)
   `U8SV_ASSERT_NEXT(a_error_sticky, clock, reset,
      error_seen_ff && !(s1_fire && s1_last_ff), error_seen_ff)
   `U8SV_ASSERT_NEXT(a_verdict_tracks, clock, reset, s1_fire && !s1_last_ff,
      rsp_valid_ff && rsp_ok_ff == !error_seen_ff)

endmodule

// ----- test/utf8_stream_validator_tb.sv -----
// testbench for the utf-8 stream validator: directed table, random strings, per-beat verdicts
`timescale 1ns / 100ps

module utf8_stream_validator_tb;
   import u8sv_pkg::*;

   localparam int RandomBytes = 650;
   localparam int IdleLimit   = 3000;
   localparam int HoldCycles  = 300;
   localparam int TailCycles  = 8;

   typedef struct packed {
      logic ok;
      logic closes;
   } verdict_type;

   typedef struct {
      byte_type b;
      bit       last;
      bit       typed;
      bit       want;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   // predictor state
   count_type pend_left = '0;
   count_type seq_len   = '0;
   point_type point_acc = '0;
   logic      bad_seen  = 1'b0;

   verdict_type verdict_q[$];
   byte_type  string_bytes[$];
   int        errors = 0;
   int        rsp_seen = 0;
   int        idle_cycles = 0;
   int        burst_left = 0;

   // receiver stall pattern
   int        phase_left = 0;
   int        phase_kind = 0;
   int        hold_left = 0;
   bit        held = 1'b0;
   logic [7:0] stall_mask = 8'b1011_0010;

   row_type dir_rows [0:27] = '{
      '{8'h41, 1'b1, 1'b1, 1'b1},
      '{8'h00, 1'b1, 1'b1, 1'b0},
      '{8'h7F, 1'b1, 1'b1, 1'b1},
      '{8'hFF, 1'b1, 1'b1, 1'b0},
      '{8'hC0, 1'b1, 1'b1, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b0},
      '{8'hC2, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0},
      '{8'hDF, 1'b1, 1'b1, 1'b0},
      '{8'hE0, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0},
      '{8'hED, 1'b0, 1'b0, 1'b0},
      '{8'hA0, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0},
      '{8'hF4, 1'b0, 1'b0, 1'b0},
      '{8'h8F, 1'b0, 1'b0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 1'b0},
      '{8'hBF, 1'b1, 1'b0, 1'b0},
      '{8'hF4, 1'b0, 1'b0, 1'b0},
      '{8'h90, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0},
      '{8'hC2, 1'b0, 1'b0, 1'b0},
      '{8'h41, 1'b1, 1'b0, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0}
   };

   utf8_stream_validator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic verdict_type judge_byte(input byte_type b, input logic last);
      point_type   pt;
      verdict_type v;
      if (!bad_seen) begin
         if (pend_left == 0) begin
            if (b <= 8'h7F) begin
               if (b == 8'h00) bad_seen = 1'b1;
            end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
               pend_left = LEN_ONE;
               seq_len   = LEN_ONE;
               point_acc = point_type'(b[4:0]);
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
               pend_left = LEN_TWO;
               seq_len   = LEN_TWO;
               point_acc = point_type'(b[3:0]);
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
               pend_left = LEN_THREE;
               seq_len   = LEN_THREE;
               point_acc = point_type'(b[2:0]);
            end else begin
               bad_seen = 1'b1;
            end
         end else if ((b & CONT_MASK) != CONT_TAG) begin
            bad_seen = 1'b1;
         end else begin
            pt = {point_acc[14:0], b[5:0]};
            point_acc = pt;
            pend_left = pend_left - 2'd1;
            if (pend_left == 0 &&
                ((seq_len == LEN_TWO && pt < MIN_THREE) ||
                 (seq_len == LEN_THREE && pt < MIN_FOUR) ||
                 (pt >= SURR_LO && pt <= SURR_HI) ||
                 pt > POINT_MAX))
               bad_seen = 1'b1;
         end
      end
      if (last && pend_left != 0) bad_seen = 1'b1;
      v.ok     = !bad_seen;
      v.closes = last;
      if (last) begin
         pend_left = '0;
         seq_len   = '0;
         point_acc = '0;
         bad_seen  = 1'b0;
      end
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic send_beat(input byte_type b, input bit last, input bit typed, input bit want);
      int          gap;
      verdict_type v;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      v = judge_byte(b, last);
      if (typed) v.ok = want;
      verdict_q.push_back(v);
   endtask

   task automatic push_point(input logic [20:0] cp, input int nb);
      case (nb)
         1: string_bytes.push_back(cp[7:0]);
         2: begin
            string_bytes.push_back({3'b110, cp[10:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            string_bytes.push_back({4'b1110, cp[15:12]});
            string_bytes.push_back({2'b10, cp[11:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            string_bytes.push_back({5'b11110, cp[20:18]});
            string_bytes.push_back({2'b10, cp[17:12]});
            string_bytes.push_back({2'b10, cp[11:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic make_string();
      int          points;
      int          kind;
      int          nb;
      logic [20:0] cp;
      string_bytes.delete();
      points = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      repeat (points) begin
         kind = $urandom_range(0, 39);
         if (kind <= 13) begin
            push_point(21'($urandom_range(1, 'h7F)), 1);
         end else if (kind <= 20) begin
            push_point(21'($urandom_range('h80, 'h7FF)), 2);
         end else if (kind <= 27) begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h2000;
            push_point(cp, 3);
         end else if (kind <= 33) begin
            push_point(21'($urandom_range('h10000, 'h10FFFF)), 4);
         end else if (kind == 34) begin
            push_point(21'($urandom_range('hD800, 'hDFFF)), 3);
         end else if (kind == 35) begin
            // overlong forms
            if ($urandom_range(0, 1) == 0) push_point(21'($urandom_range(0, 'h7FF)), 3);
            else push_point(21'($urandom_range(0, 'hFFFF)), 4);
         end else if (kind == 36) begin
            push_point(21'($urandom_range('h110000, 'h1FFFFF)), 4);
         end else if (kind == 37) begin
            string_bytes.push_back(byte_type'($urandom_range(0, 255)));
         end else if (kind == 38) begin
            // sequence cut short
            nb = $urandom_range(2, 4);
            case (nb)
               2: cp = 21'($urandom_range('h80, 'h7FF));
               3: cp = 21'($urandom_range('h800, 'hD7FF));
               default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
            push_point(cp, nb);
            repeat ($urandom_range(1, nb - 1)) void'(string_bytes.pop_back());
         end else begin
            case ($urandom_range(0, 3))
               0: string_bytes.push_back(8'h00);
               1: string_bytes.push_back(byte_type'($urandom_range('h80, 'hBF)));
               2: string_bytes.push_back(byte_type'($urandom_range('hC0, 'hC1)));
               default: string_bytes.push_back(byte_type'($urandom_range('hF5, 'hFF)));
            endcase
         end
      end
   endtask

   initial begin
      int rand_sent;
      int i;
      rand_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[k])
         send_beat(dir_rows[k].b, dir_rows[k].last, dir_rows[k].typed, dir_rows[k].want);
      while (rand_sent < RandomBytes) begin
         make_string();
         for (i = 0; i < string_bytes.size(); i++)
            send_beat(string_bytes[i], i == string_bytes.size() - 1, 1'b0, 1'b0);
         rand_sent += string_bytes.size();
      end
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // receiver: random phases, one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!held && rsp_seen >= 150) begin
         held <= 1'b1;
         hold_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            phase_kind <= $urandom_range(0, 3);
            phase_left <= $urandom_range(16, 80);
         end else begin
            phase_left <= phase_left - 1;
         end
         case (phase_kind)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_tready <= stall_mask[0];
               stall_mask <= {stall_mask[0], stall_mask[7:1]};
            end
         endcase
      end
   end

   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen <= rsp_seen + 1;
         if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat tdata=%02h tlast=%0b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            v = verdict_q.pop_front();
            if (rsp_tdata[0] !== v.ok)
               report_mismatch($sformatf("string_valid got %0b want %0b", rsp_tdata[0], v.ok));
            if (rsp_tdata[7:1] !== 7'd0)
               report_mismatch($sformatf("padding got %02h want 00", rsp_tdata[7:1]));
            if (rsp_tlast !== v.closes)
               report_mismatch($sformatf("string_end got %0b want %0b", rsp_tlast, v.closes));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
